/* sv/wplm_pkg.sv */
`timescale 1ns / 1ps

package wplm_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } state_t;

    // Configuration register indexes
    localparam logic REG_FRAMES_PER_PERIOD = 1'b0;
    localparam logic REG_CLIP_LEVEL        = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 15;

    localparam int FRAMES_W    = 13;
    localparam int FRAME_CNT_W = 12;
    localparam int PEAK_W      = 15;

    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 13'd1024;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX   = 13'd4096;
    localparam logic [PEAK_W-1:0]   CLIP_RESET   = 15'd32767;
    localparam logic [PEAK_W-1:0]   PEAK_MAX     = 15'd32767;

    // Result tdata: channel, peak, clip, any_clip, padded to whole bytes
    localparam int OUT_FIELDS_W = 1 + PEAK_W + 1 + 1;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

/* sv/wplm_ram.sv */
`timescale 1ns / 1ps

module wplm_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/windowed_peak_level_meter.sv */
`timescale 1ns / 1ps

// Windowed peak level meter.
// s_* channel: one signed audio sample per transaction, channels interleaved,
//   channel 0 first. The low SAMPLE_BITS bits of s_tdata are the sample.
// m_* channel: CHANNELS results after each period end, in channel order, each
//   the maximum magnitude over the last HISTORY_PERIODS periods of that channel
//   with its clip flag; tlast and any_clip mark the final result of a period.
// cfg_* port: register 0 frames_per_period, register 1 clip_level; write only
//   while no sample is in flight.
// Each sample is a read, then a write back of one peak entry in the history
//   RAM; the next sample is taken only after that write back. After the sample
//   that closes a period the block walks the RAM, one read per cycle, then
//   hands out the results; no sample is taken during the walk or the hand out.
// Reset: counters, slot pointer and registers return to defaults; the RAM is
//   not cleared, a fill count masks slots not yet written as zero.
// A stalled receiver holds the output register; the block keeps taking
//   samples and only waits when the next results are due.
module windowed_peak_level_meter #(
    parameter int CHANNELS        = 2,
    parameter int HISTORY_PERIODS = 8,
    parameter int SAMPLE_BITS     = 16,
    localparam int IN_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // sample transactions
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [IN_W-1:0]                    s_tdata,  // sample
    // result transactions
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [wplm_pkg::OUT_W-1:0]         m_tdata,  // channel, peak, clip, any_clip
    output logic                               m_tlast,
    // configuration writes
    input  logic                               cfg_we,
    input  logic [wplm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [wplm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DEPTH = CHANNELS * HISTORY_PERIODS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW    = (HISTORY_PERIODS > 1) ? $clog2(HISTORY_PERIODS) : 1;
    localparam int FW    = $clog2(HISTORY_PERIODS + 1);
    localparam int MW    = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int PW    = wplm_pkg::PEAK_W;

    localparam logic [CW-1:0] LAST_CH   = CW'(CHANNELS - 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(HISTORY_PERIODS - 1);
    localparam logic [FW-1:0] FULL      = FW'(HISTORY_PERIODS);
    localparam logic [AW-1:0] CH_STEP   = AW'(CHANNELS);

    wplm_pkg::state_t state_reg, state_next;

    logic [wplm_pkg::FRAMES_W-1:0]    frames_reg;
    logic [PW-1:0]                    clip_level_reg;
    logic [wplm_pkg::FRAME_CNT_W-1:0] frame_count_reg;
    logic [CW-1:0]                    pos_reg;
    logic [SW-1:0]                    slot_reg;
    logic [AW-1:0]                    base_reg;
    logic [FW-1:0]                    filled_reg;

    logic [PW-1:0]                    mag_reg;
    logic                             first_frame_reg;
    logic [AW-1:0]                    upd_addr_reg;

    logic [CW-1:0]                    scan_ch_reg;
    logic [SW-1:0]                    scan_slot_reg;
    logic [AW-1:0]                    scan_addr_reg;
    logic                             rd_valid_reg;
    logic                             rd_ok_reg;
    logic                             rd_first_reg;
    logic                             rd_last_reg;
    logic [CW-1:0]                    rd_ch_reg;
    logic [PW-1:0]                    acc_reg;
    logic [PW-1:0]                    peaks_reg [CHANNELS];
    logic                             any_reg;

    logic [CW-1:0]                    emit_reg;
    logic                             out_valid_reg;
    logic [wplm_pkg::OUT_W-1:0]       out_data_reg;
    logic                             out_last_reg;

    logic                             accept;
    logic                             out_load;
    logic                             emit_done;
    logic                             scan_done;
    logic                             period_end;
    logic [wplm_pkg::FRAMES_W-1:0]    period_len;
    logic [SAMPLE_BITS-1:0]           raw;
    logic [SAMPLE_BITS-1:0]           neg_raw;
    logic [MW-1:0]                    mag_wide;
    logic [PW-1:0]                    mag;
    logic                             ram_we;
    logic [AW-1:0]                    ram_raddr;
    logic [PW-1:0]                    ram_rdata;
    logic [PW-1:0]                    old_peak;
    logic [PW-1:0]                    new_peak;
    logic [PW-1:0]                    scan_val;
    logic [PW-1:0]                    scan_cand;
    logic [PW-1:0]                    emit_peak;
    logic                             emit_last;

    // Saturated magnitude of the incoming sample
    always_comb
    begin
        raw      = s_tdata[SAMPLE_BITS-1:0];
        neg_raw  = ~raw + 1'b1;
        mag_wide = raw[SAMPLE_BITS-1] ? MW'(neg_raw) : MW'(raw);
        mag      = (mag_wide > MW'(wplm_pkg::PEAK_MAX)) ? wplm_pkg::PEAK_MAX
                                                         : mag_wide[PW-1:0];
    end

    // Clamp the period length and test for the last frame
    always_comb
    begin
        if (frames_reg == '0)
        begin
            period_len = wplm_pkg::FRAMES_W'(1);
        end
        else if (frames_reg > wplm_pkg::FRAMES_MAX)
        begin
            period_len = wplm_pkg::FRAMES_MAX;
        end
        else
        begin
            period_len = frames_reg;
        end
        period_end = (pos_reg == LAST_CH)
                  && (({1'b0, frame_count_reg} + wplm_pkg::FRAMES_W'(1)) >= period_len);
    end

    // Read-modify-write of one peak entry; a new period starts from zero
    assign old_peak = first_frame_reg ? '0 : ram_rdata;
    assign new_peak = (mag_reg > old_peak) ? mag_reg : old_peak;

    // Window scan: slots not yet written since reset read as zero
    assign scan_val  = rd_ok_reg ? ram_rdata : '0;
    assign scan_cand = (rd_first_reg || scan_val > acc_reg) ? scan_val : acc_reg;

    assign accept    = s_tvalid && s_tready;
    assign scan_done = (scan_ch_reg == LAST_CH) && (scan_slot_reg == LAST_SLOT);
    assign out_load  = (state_reg == wplm_pkg::S_EMIT) && (!out_valid_reg || m_tready);
    assign emit_last = (emit_reg == LAST_CH);
    assign emit_done = out_load && emit_last;
    assign emit_peak = peaks_reg[emit_reg];

    assign ram_we    = (state_reg == wplm_pkg::S_UPDATE);
    assign ram_raddr = (state_reg == wplm_pkg::S_SCAN) ? scan_addr_reg : base_reg + AW'(pos_reg);

    wplm_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (upd_addr_reg),
        .wdata (new_peak),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wplm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and input handshake
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            wplm_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = wplm_pkg::S_UPDATE;
                end
            end
            wplm_pkg::S_UPDATE:
            begin
                state_next = period_end ? wplm_pkg::S_SCAN : wplm_pkg::S_IDLE;
            end
            wplm_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = wplm_pkg::S_DRAIN;
                end
            end
            wplm_pkg::S_DRAIN:
            begin
                state_next = wplm_pkg::S_EMIT;
            end
            wplm_pkg::S_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = wplm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wplm_pkg::S_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg     <= wplm_pkg::FRAMES_RESET;
            clip_level_reg <= wplm_pkg::CLIP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wplm_pkg::REG_FRAMES_PER_PERIOD: frames_reg <= cfg_data[wplm_pkg::FRAMES_W-1:0];
                wplm_pkg::REG_CLIP_LEVEL:        clip_level_reg <= cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    // Capture the sample and its RAM address
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg         <= mag;
            first_frame_reg <= (frame_count_reg == '0);
            upd_addr_reg    <= base_reg + AW'(pos_reg);
        end
    end

    // Advance channel, frame and slot counters after each write back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            pos_reg         <= '0;
            slot_reg        <= '0;
            base_reg        <= '0;
            filled_reg      <= '0;
        end
        else if (state_reg == wplm_pkg::S_UPDATE)
        begin
            if (pos_reg != LAST_CH)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            else
            begin
                pos_reg <= '0;
                if (period_end)
                begin
                    frame_count_reg <= '0;
                    if (slot_reg == LAST_SLOT)
                    begin
                        slot_reg <= '0;
                        base_reg <= '0;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + 1'b1;
                        base_reg <= base_reg + CH_STEP;
                    end
                    if (filled_reg != FULL)
                    begin
                        filled_reg <= filled_reg + 1'b1;
                    end
                end
                else
                begin
                    frame_count_reg <= frame_count_reg + 1'b1;
                end
            end
        end
    end

    // Walk the ring: channel by channel, every slot of that channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_ch_reg   <= '0;
            scan_slot_reg <= '0;
            scan_addr_reg <= '0;
            rd_valid_reg  <= 1'b0;
            any_reg       <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= (state_reg == wplm_pkg::S_SCAN);
            if (state_reg == wplm_pkg::S_UPDATE)
            begin
                scan_ch_reg   <= '0;
                scan_slot_reg <= '0;
                scan_addr_reg <= '0;
                any_reg       <= 1'b0;
            end
            else if (state_reg == wplm_pkg::S_SCAN)
            begin
                if (scan_slot_reg == LAST_SLOT)
                begin
                    scan_slot_reg <= '0;
                    scan_ch_reg   <= scan_ch_reg + 1'b1;
                    scan_addr_reg <= AW'(scan_ch_reg) + AW'(1);
                end
                else
                begin
                    scan_slot_reg <= scan_slot_reg + 1'b1;
                    scan_addr_reg <= scan_addr_reg + CH_STEP;
                end
            end
            if (rd_valid_reg && rd_last_reg && (scan_cand >= clip_level_reg))
            begin
                any_reg <= 1'b1;
            end
        end
    end

    // Tag each read and fold the returned value into the running maximum
    always_ff @(posedge clk)
    begin
        rd_ok_reg    <= (FW'(scan_slot_reg) < filled_reg);
        rd_first_reg <= (scan_slot_reg == '0);
        rd_last_reg  <= (scan_slot_reg == LAST_SLOT);
        rd_ch_reg    <= scan_ch_reg;
        if (rd_valid_reg)
        begin
            acc_reg <= scan_cand;
            if (rd_last_reg)
            begin
                peaks_reg[rd_ch_reg] <= scan_cand;
            end
        end
    end

    // Step through the channels while results are handed out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                emit_reg      <= emit_last ? '0 : emit_reg + 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {{(wplm_pkg::OUT_W - wplm_pkg::OUT_FIELDS_W){1'b0}},
                             emit_last && any_reg,
                             emit_peak >= clip_level_reg,
                             emit_peak,
                             emit_reg[0]};
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
